[rtl/tsd_pkg.sv]
// Shared types and constants for the touch swipe direction detector.
// Holds event codes, direction codes and the structs passed between modules.
// No dependencies.
package tsd_pkg;

	localparam int COORD_BITS = 12;
	localparam int THR_BITS   = 12;
	localparam int TYPE_BITS  = 16;
	localparam int CODE_BITS  = 16;
	localparam int VALUE_BITS = 12;
	localparam int DIR_BITS   = 3;
	localparam int IN_BITS    = 48;
	localparam int OUT_BITS   = 8;
	localparam int ADDR_BITS  = 3;
	localparam int DATA_BITS  = 32;

	localparam logic [TYPE_BITS-1:0] EVT_KEY    = 16'h0001;
	localparam logic [TYPE_BITS-1:0] EVT_ABS    = 16'h0003;
	localparam logic [CODE_BITS-1:0] CODE_TOUCH = 16'h014A;
	localparam logic [CODE_BITS-1:0] CODE_ABS_X = 16'h0000;
	localparam logic [CODE_BITS-1:0] CODE_ABS_Y = 16'h0001;

	localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 12'd25;

	// register index of swipe_threshold (byte address 4 * index)
	localparam logic [ADDR_BITS-3:0] REG_THRESHOLD = 1'b0;

	typedef enum logic [DIR_BITS-1:0] {
		DIR_UP    = 3'd0,
		DIR_DOWN  = 3'd1,
		DIR_LEFT  = 3'd2,
		DIR_RIGHT = 3'd3,
		DIR_NONE  = 3'd4
	} dir_t;

	typedef enum logic [2:0] {
		EV_OTHER,
		EV_PRESS,
		EV_RELEASE,
		EV_X,
		EV_Y
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t               kind;
		logic [COORD_BITS-1:0]  coord;
	} ev_t;

	typedef struct packed {
		logic pressed;
		logic expect_y;
		logic x_latched;
		logic y_latched;
	} gst_t;

endpackage

[rtl/tsd_decode.sv]
// Event classifier: turns a raw (type, code, value) item into an event kind.
// Depends on tsd_pkg.
module tsd_decode
	import tsd_pkg::*;
(
	input  logic [TYPE_BITS-1:0]  event_type,
	input  logic [CODE_BITS-1:0]  event_code,
	input  logic [VALUE_BITS-1:0] event_value,
	output ev_t                   ev
);

	always_comb begin
		ev.coord = COORD_BITS'(event_value);
		ev.kind  = EV_OTHER;
		if (event_type == EVT_KEY && event_code == CODE_TOUCH) begin
			ev.kind = (event_value != '0) ? EV_PRESS : EV_RELEASE;
		end else if (event_type == EVT_ABS && event_code == CODE_ABS_X) begin
			ev.kind = EV_X;
		end else if (event_type == EVT_ABS && event_code == CODE_ABS_Y) begin
			ev.kind = EV_Y;
		end
	end

endmodule

[rtl/tsd_gesture.sv]
// Gesture state (press, X/Y alternation, start and end points) and the
// direction decision taken on release. Depends on tsd_pkg.
module tsd_gesture
	import tsd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  ev_t                 ev,
	input  logic [THR_BITS-1:0] threshold,
	output dir_t                direction,
	output gst_t                status
);

	gst_t                  st_q;
	logic [COORD_BITS-1:0] x_start_q, y_start_q, x_end_q, y_end_q;

	logic signed [COORD_BITS:0] dx, dy;
	logic [COORD_BITS-1:0]      ax, ay;
	logic                       take_x, take_y;

	assign take_x = (ev.kind == EV_X) && !st_q.expect_y;
	assign take_y = (ev.kind == EV_Y) && st_q.expect_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			if (ev.kind == EV_RELEASE) begin
				st_q <= '0;
			end else if (ev.kind == EV_PRESS) begin
				st_q.pressed <= 1'b1;
			end else if (take_x) begin
				st_q.expect_y <= 1'b1;
				if (st_q.pressed) st_q.x_latched <= 1'b1;
			end else if (take_y) begin
				st_q.expect_y <= 1'b0;
				if (st_q.pressed) st_q.y_latched <= 1'b1;
			end
		end
	end

	// positions are only read once their latched flag is set
	always_ff @(posedge clk) begin
		if (advance && take_x) begin
			x_end_q <= ev.coord;
			if (st_q.pressed && !st_q.x_latched) x_start_q <= ev.coord;
		end
		if (advance && take_y) begin
			y_end_q <= ev.coord;
			if (st_q.pressed && !st_q.y_latched) y_start_q <= ev.coord;
		end
	end

	always_comb begin
		dx = $signed({1'b0, x_end_q}) - $signed({1'b0, x_start_q});
		dy = $signed({1'b0, y_end_q}) - $signed({1'b0, y_start_q});
		ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
		ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
		direction = DIR_NONE;
		if (st_q.x_latched && st_q.y_latched) begin
			priority if (THR_BITS'(ax) >= threshold && ax > ay) begin
				direction = dx[COORD_BITS] ? DIR_LEFT : DIR_RIGHT;
			end else if (THR_BITS'(ay) >= threshold && ay > ax) begin
				direction = dy[COORD_BITS] ? DIR_UP : DIR_DOWN;
			end else begin
				direction = DIR_NONE;
			end
		end
	end

	assign status = st_q;

endmodule

[rtl/touch_swipe_direction_detector.sv]
// Top level of the touch swipe direction detector: stream ports, APB
// threshold register, input stage and result register.
// Depends on tsd_pkg, tsd_decode and tsd_gesture.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+--------------------------------------
//  s_axis  | in  | s_tvalid / s_tready  | s_tdata: event_type, event_code,
//          |     |                      |          event_value, zero pad
//  m_axis  | out | m_tvalid / m_tready  | m_tdata: direction, zero pad
//  apb     | in  | psel/penable/pready  | swipe_threshold at byte address 0
//
// One item is taken per cycle unless a release is stalled in stage 1. An item
// is classified on entry and held in the stage-1 register; from there it
// updates the gesture state and, on a touch release, loads the direction into
// the result register, which drives m_tvalid. A release that meets a stalled
// result waits in stage 1 and holds the input until the result is taken;
// other items keep flowing.
// arst_n clears the gesture state, both valid flags and sets the threshold
// to 25.
module touch_swipe_direction_detector
	import tsd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// s_tdata: [15:0] event_type, [31:16] event_code, [43:32] event_value,
	//          [47:44] zero
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_BITS-1:0]   s_tdata,
	// m_tdata: [2:0] direction, [7:3] zero
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_BITS-1:0]  m_tdata,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready
);

	logic [THR_BITS-1:0] threshold_q;
	ev_t                 ev_in;
	ev_t                 ev_s1;
	logic                valid_s1;
	logic                adv_s1;
	logic                out_free;
	logic                is_release_s1;
	dir_t                direction;
	dir_t                dir_q;
	logic                m_valid_q;
	gst_t                gst;

	// ---------------- configuration ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[ADDR_BITS-1:2] == REG_THRESHOLD) begin
			threshold_q <= pwdata[THR_BITS-1:0];
		end
	end

	// a single register: byte addresses 0 to 3 read it, the others read zero
	assign prdata = (paddr[ADDR_BITS-1:2] == REG_THRESHOLD)
		? DATA_BITS'(threshold_q) : '0;

	// ---------------- input stage ----------------
	tsd_decode u_decode (
		.event_type  (s_tdata[15:0]),
		.event_code  (s_tdata[31:16]),
		.event_value (s_tdata[43:32]),
		.ev          (ev_in)
	);

	// only a release needs room in the result register
	assign out_free      = !m_valid_q || m_tready;
	assign is_release_s1 = (ev_s1.kind == EV_RELEASE);
	assign adv_s1        = valid_s1 && (!is_release_s1 || out_free);
	assign s_tready      = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) ev_s1 <= ev_in;
	end

	// ---------------- gesture state and decision ----------------
	tsd_gesture u_gesture (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (adv_s1),
		.ev        (ev_s1),
		.threshold (threshold_q),
		.direction (direction),
		.status    (gst)
	);

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv_s1 && is_release_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && is_release_s1) dir_q <= direction;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_BITS'(dir_q);

	// ---------------- assertions ----------------
	// a release always leaves the gesture fully cleared
	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && is_release_s1) |=> (gst == '0))
		else $error("gesture state not cleared after release");

	// input only stalls behind a release waiting on a busy result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && is_release_s1 && m_valid_q && !m_tready))
		else $error("input stalled without a blocked release");

	// a start point is never latched while the touch is up
	a_latch_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		(gst.x_latched || gst.y_latched) |-> gst.pressed)
		else $error("start point latched without press");

	// a new result appears only after a release left stage 1
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(adv_s1 && is_release_s1))
		else $error("result without release");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for touch_swipe_direction_detector: random touch event
// streams with a scoreboard that predicts every swipe direction.
// Depends on tsd_pkg and the detector RTL.

module tb;
	import tsd_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_EVENTS = 268;	// gesture items per threshold setting
	localparam int DRAIN_CYCLES = 8;	// extra clocks before the final summary

	// Tracks the gesture exactly as the detector should, and holds the
	// directions still owed by the block, oldest first.
	class swipe_scoreboard;
		logic [THR_BITS-1:0]   threshold;
		bit                    pressed;
		bit                    want_y;
		bit                    x_set;
		bit                    y_set;
		logic [COORD_BITS-1:0] x_start;
		logic [COORD_BITS-1:0] y_start;
		logic [COORD_BITS-1:0] x_end;
		logic [COORD_BITS-1:0] y_end;
		dir_t                  expected_dirs[$];
		int                    taken;
		int                    errors;
		int                    dir_count[5];

		function new();
			threshold = THRESHOLD_RESET;
			clear_gesture();
		endfunction

		function void clear_gesture();
			pressed = 0;
			want_y  = 0;
			x_set   = 0;
			y_set   = 0;
			x_start = '0;
			y_start = '0;
			x_end   = '0;
			y_end   = '0;
		endfunction

		// Larger axis wins when it reaches the threshold; ties give none.
		function dir_t swipe_direction();
			int dx, dy, ax, ay, thr;
			if (!x_set || !y_set)
				return DIR_NONE;
			dx  = int'(x_end) - int'(x_start);
			dy  = int'(y_end) - int'(y_start);
			ax  = dx < 0 ? -dx : dx;
			ay  = dy < 0 ? -dy : dy;
			thr = int'(threshold);
			if (ax >= thr && ax > ay)
				return dx > 0 ? DIR_RIGHT : DIR_LEFT;
			if (ay >= thr && ay > ax)
				return dy > 0 ? DIR_DOWN : DIR_UP;
			return DIR_NONE;
		endfunction

		// Apply one accepted item; ignored items leave taken untouched.
		function void note_event(input logic [TYPE_BITS-1:0] etype,
				input logic [CODE_BITS-1:0] ecode, input logic [VALUE_BITS-1:0] evalue);
			dir_t d;
			if (etype == EVT_KEY && ecode == CODE_TOUCH) begin
				taken++;
				if (evalue != 0) begin
					pressed = 1;
				end else begin
					d = swipe_direction();
					expected_dirs.push_back(d);
					dir_count[int'(d)]++;
					clear_gesture();
				end
			end else if (etype == EVT_ABS && ecode == CODE_ABS_X && !want_y) begin
				taken++;
				if (pressed && !x_set) begin
					x_start = evalue[COORD_BITS-1:0];
					x_set   = 1;
				end
				x_end  = evalue[COORD_BITS-1:0];
				want_y = 1;
			end else if (etype == EVT_ABS && ecode == CODE_ABS_Y && want_y) begin
				taken++;
				if (pressed && !y_set) begin
					y_start = evalue[COORD_BITS-1:0];
					y_set   = 1;
				end
				y_end  = evalue[COORD_BITS-1:0];
				want_y = 0;
			end
		endfunction

		function void check_dir(input logic [OUT_BITS-1:0] got);
			dir_t want;
			if (expected_dirs.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual 0x%02h", $time, got);
				return;
			end
			want = expected_dirs.pop_front();
			if (got !== {{(OUT_BITS-DIR_BITS){1'b0}}, want}) begin
				errors++;
				$display("%0t: direction mismatch, expected %s (0x%02h), actual 0x%02h",
					$time, want.name(), {{(OUT_BITS-DIR_BITS){1'b0}}, want}, got);
			end
		endfunction

		function int pending();
			return expected_dirs.size();
		endfunction
	endclass

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// s_tdata: [15:0] event_type, [31:16] event_code, [43:32] event_value, [47:44] zero
	logic [IN_BITS-1:0]   s_tdata  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// m_tdata: [2:0] direction, [7:3] zero
	logic [OUT_BITS-1:0]  m_tdata;
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [ADDR_BITS-1:0] paddr    = '0;
	logic [DATA_BITS-1:0] pwdata   = '0;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	swipe_scoreboard sb = new();

	bit src_calm;		// sender runs without gaps
	bit sink_calm;		// receiver runs without stalls
	int stall_left;
	int cycles;
	int settings_run;

	touch_swipe_direction_detector dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #10 clk = ~clk;

	// Mostly short idle stretches, now and then a long one.
	function automatic int gap_length();
		int r;
		if (src_calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Receiver: random back-pressure, with calm stretches toggled at random.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 149) == 0)
				sink_calm = !sink_calm;
			if (!sink_calm && $urandom_range(0, 3) == 0)
				stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
					: $urandom_range(10, 40);
		end
	end

	// Check every result taken by the receiver; values seen here are pre-edge.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_dir(m_tdata);
	end

	// Hard stop in case the block hangs.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d directions still owed", cycles, sb.pending());
		$display("status: fail");
		$finish;
	end

	// Offer one item after a random gap, hold it until taken, then return at
	// the next falling edge. Valid stays high when the next item follows at once.
	task automatic push_event(input logic [TYPE_BITS-1:0] etype,
			input logic [CODE_BITS-1:0] ecode, input logic [VALUE_BITS-1:0] evalue);
		int gap;
		gap = gap_length();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_BITS-TYPE_BITS-CODE_BITS-VALUE_BITS){1'b0}}, evalue, ecode, etype};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_event(etype, ecode, evalue);
		@(negedge clk);
	endtask

	// Junk the block must drop: foreign types and codes, axis out of turn.
	task automatic push_noise();
		case ($urandom_range(0, 3))
			0: push_event(TYPE_BITS'($urandom_range(0, 16'hFFFF)),
				CODE_BITS'($urandom_range(0, 16'hFFFF)),
				VALUE_BITS'($urandom_range(0, 12'hFFF)));
			1: push_event(EVT_KEY, CODE_BITS'($urandom_range(0, 16'hFFFF)),
				VALUE_BITS'($urandom_range(0, 12'hFFF)));
			2: push_event(EVT_ABS, CODE_BITS'($urandom_range(2, 16'hFFFF)),
				VALUE_BITS'($urandom_range(0, 12'hFFF)));
			default: push_event(EVT_ABS, sb.want_y ? CODE_ABS_X : CODE_ABS_Y,
				VALUE_BITS'($urandom_range(0, 12'hFFF)));
		endcase
	endtask

	// One X report and, unless the pair is cut short, its Y report.
	task automatic push_pair(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
			input bit with_y);
		if ($urandom_range(0, 99) < 8)
			push_noise();
		push_event(EVT_ABS, CODE_ABS_X, x);
		if ($urandom_range(0, 99) < 8)
			push_noise();
		if (with_y)
			push_event(EVT_ABS, CODE_ABS_Y, y);
	endtask

	// Displacement near the current threshold, sometimes anything at all.
	function automatic int swipe_span();
		int m;
		if ($urandom_range(0, 4) == 0)
			return $urandom_range(0, 4095);
		m = int'(sb.threshold) + int'($urandom_range(0, 4)) - 2;
		return m < 0 ? 0 : (m > 4095 ? 4095 : m);
	endfunction

	// Pick start and end on one axis, the given distance apart, either sign.
	function automatic void place(input int mag, output logic [COORD_BITS-1:0] a,
			output logic [COORD_BITS-1:0] b);
		if ($urandom_range(0, 1)) begin
			a = COORD_BITS'($urandom_range(0, 4095 - mag));
			b = COORD_BITS'(int'(a) + mag);
		end else begin
			a = COORD_BITS'($urandom_range(mag, 4095));
			b = COORD_BITS'(int'(a) - mag);
		end
	endfunction

	// Mostly well-formed gestures with random geometry; a share are broken.
	task automatic run_gesture();
		int kind, style, mag_main, mag_side;
		bit x_main;
		logic [COORD_BITS-1:0] xs, ys, xe, ye;
		src_calm = ($urandom_range(0, 4) == 0);
		kind     = $urandom_range(0, 99);
		if (kind < 5) begin
			// release with no press
			push_event(EVT_KEY, CODE_TOUCH, '0);
			return;
		end
		if (kind < 12)
			push_pair(COORD_BITS'($urandom_range(0, 4095)),
				COORD_BITS'($urandom_range(0, 4095)), 1'b1);
		push_event(EVT_KEY, CODE_TOUCH, VALUE_BITS'($urandom_range(1, 4095)));
		if (kind >= 95)
			push_event(EVT_KEY, CODE_TOUCH, VALUE_BITS'($urandom_range(1, 4095)));
		if (kind >= 12 && kind < 17) begin
			// press and release with no coordinates
			push_event(EVT_KEY, CODE_TOUCH, '0);
			return;
		end
		x_main   = ($urandom_range(0, 1) != 0);
		style    = $urandom_range(0, 3);
		mag_main = swipe_span();
		case (style)
			0: mag_side = $urandom_range(0, mag_main);
			1: mag_side = mag_main;
			2: mag_side = $urandom_range(0, 4095);
			default: mag_side = swipe_span();
		endcase
		if (x_main) begin
			place(mag_main, xs, xe);
			place(mag_side, ys, ye);
		end else begin
			place(mag_side, xs, xe);
			place(mag_main, ys, ye);
		end
		push_pair(xs, ys, 1'b1);
		repeat ($urandom_range(0, 3))
			push_pair(COORD_BITS'($urandom_range(0, 4095)),
				COORD_BITS'($urandom_range(0, 4095)), 1'b1);
		// drop the final Y now and then, so the end point stays half updated
		push_pair(xe, ye, !(kind >= 17 && kind < 25));
		push_event(EVT_KEY, CODE_TOUCH, '0);
	endtask

	task automatic run_phase();
		int start;
		start = sb.taken;
		while (sb.taken - start < PHASE_EVENTS)
			run_gesture();
	endtask

	// Drop valid and wait until the block has nothing left in flight.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Optionally write the threshold, then read it back and compare.
	task automatic threshold_access(input bit do_write, input logic [THR_BITS-1:0] value);
		logic [DATA_BITS-1:0] got;
		if (do_write) begin
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= {REG_THRESHOLD, 2'b00};
			pwdata  <= {{(DATA_BITS-THR_BITS){1'b0}}, value};
			@(negedge clk);
			penable <= 1'b1;
			do
				@(posedge clk);
			while (!pready);
			sb.threshold = value;
			settings_run++;
			@(negedge clk);
		end
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {REG_THRESHOLD, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		got = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== {{(DATA_BITS-THR_BITS){1'b0}}, sb.threshold}) begin
			sb.errors++;
			$display("%0t: threshold readback mismatch, expected 0x%08h, actual 0x%08h",
				$time, {{(DATA_BITS-THR_BITS){1'b0}}, sb.threshold}, got);
		end
	endtask

	initial begin
		logic [THR_BITS-1:0] plan[6];
		plan[0] = 12'd0;
		plan[1] = 12'd4095;
		plan[2] = 12'd1;
		plan[3] = THR_BITS'($urandom_range(2, 64));
		plan[4] = THR_BITS'($urandom_range(65, 4094));
		plan[5] = THRESHOLD_RESET;

		// hold reset, then release it away from the rising edge
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		threshold_access(1'b0, '0);
		settings_run = 1;

		// Directed part at the reset threshold of 25.
		src_calm = 1'b1;
		push_event(EVT_KEY, CODE_TOUCH, '0);			// release with no press
		push_event(EVT_KEY, CODE_TOUCH, 12'd1);			// smallest press value
		push_event(EVT_ABS, CODE_ABS_Y, 12'd7);			// Y out of turn, dropped
		push_event(EVT_ABS, CODE_ABS_X, 12'd0);
		push_event(EVT_ABS, CODE_ABS_Y, 12'd0);
		push_event(EVT_ABS, CODE_ABS_X, 12'd4095);
		push_event(EVT_ABS, CODE_ABS_Y, 12'd4095);
		push_event(EVT_KEY, CODE_TOUCH, '0);			// full-scale tie: none
		push_event(EVT_ABS, CODE_ABS_X, 12'd100);		// not pressed: no start latch
		push_event(EVT_ABS, CODE_ABS_Y, 12'd100);
		push_event(EVT_KEY, CODE_TOUCH, 12'd4095);		// largest press value
		push_event(EVT_ABS, CODE_ABS_X, 12'd100);
		push_event(EVT_ABS, CODE_ABS_Y, 12'd100);
		push_event(16'hFFFF, 16'hFFFF, 12'hFFF);		// foreign type and code
		push_event(EVT_ABS, CODE_ABS_X, 12'd160);
		push_event(EVT_ABS, CODE_ABS_Y, 12'd110);
		push_event(EVT_KEY, CODE_TOUCH, '0);			// right
		push_event(EVT_KEY, CODE_TOUCH, 12'd2);
		push_event(EVT_ABS, CODE_ABS_X, 12'd500);
		push_event(EVT_ABS, CODE_ABS_Y, 12'd500);
		push_event(EVT_KEY, CODE_ABS_X, 12'd5);			// key type with axis code
		push_event(EVT_ABS, CODE_TOUCH, 12'd9);			// axis type with touch code
		push_event(EVT_ABS, CODE_ABS_X, 12'd475);
		push_event(EVT_ABS, CODE_ABS_Y, 12'd490);
		push_event(EVT_KEY, CODE_TOUCH, '0);			// left, exactly at threshold
		push_event(EVT_KEY, CODE_TOUCH, 12'd2048);
		push_event(EVT_ABS, CODE_ABS_X, 12'd9);
		push_event(EVT_KEY, CODE_TOUCH, '0);			// no Y start: none

		run_phase();
		foreach (plan[i]) begin
			settle();
			threshold_access(1'b1, plan[i]);
			run_phase();
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d gesture items over %0d threshold settings in %0d cycles",
			sb.taken, settings_run, cycles);
		$display("releases up/down/left/right/none: %0d/%0d/%0d/%0d/%0d, mismatches: %0d",
			sb.dir_count[0], sb.dir_count[1], sb.dir_count[2], sb.dir_count[3],
			sb.dir_count[4], sb.errors);
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
